// ===== rtl/core/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// shared types, event codes and register indexes of the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int LINE_BYTES_DEF = 256;
  localparam int MAX_ARGS_DEF   = 16;

  localparam int CHAR_W    = 8;
  localparam int SET_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int EV_W      = 3;
  localparam int POS_W     = 8;
  localparam int ARG_W     = 5;
  localparam int LEN_W     = 9;

  localparam logic [EV_W-1:0] EV_STORE    = 3'd0;
  localparam logic [EV_W-1:0] EV_SEP      = 3'd1;
  localparam logic [EV_W-1:0] EV_CTRL     = 3'd2;
  localparam logic [EV_W-1:0] EV_COMMIT   = 3'd3;
  localparam logic [EV_W-1:0] EV_LINE_OVF = 3'd4;
  localparam logic [EV_W-1:0] EV_ARG_OVF  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_COMMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE = 3'd3;

  typedef struct packed {
    logic commit;
    logic delim;
    logic ctrl;
    logic ignore;
  } hit_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] value;
    logic [ARG_W-1:0]  arg_index;
    logic              starts_argument;
    logic [LEN_W-1:0]  line_length;
    logic [ARG_W-1:0]  arg_count;
  } res_t;

endpackage

// ===== rtl/core/clt_match.sv =====
// ----------------------------------------------------------------------------
// clt_match
// character set registers and parallel byte compares against the four sets
// ----------------------------------------------------------------------------
module clt_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [clt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clt_pkg::SET_W-1:0]     cfg_data,
  input  logic [clt_pkg::CHAR_W-1:0]    char_in,
  output clt_pkg::hit_t                 hits
);

  logic [clt_pkg::SET_W-1:0] commit_set_r, delim_set_r, ctrl_set_r, ignore_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_set_r <= '0;
      delim_set_r  <= '0;
      ctrl_set_r   <= '0;
      ignore_set_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        clt_pkg::REG_COMMIT: commit_set_r <= cfg_data;
        clt_pkg::REG_DELIM:  delim_set_r  <= cfg_data;
        clt_pkg::REG_CTRL:   ctrl_set_r   <= cfg_data;
        clt_pkg::REG_IGNORE: ignore_set_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic in_set(input logic [clt_pkg::SET_W-1:0] set,
                                  input logic [clt_pkg::CHAR_W-1:0] ch);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < clt_pkg::SET_W / clt_pkg::CHAR_W; k++) begin
      if (set[k*clt_pkg::CHAR_W +: clt_pkg::CHAR_W] == ch) hit = 1'b1;
    end
    return hit && (ch != '0);
  endfunction

  always_comb begin
    hits.commit = in_set(commit_set_r, char_in);
    hits.delim  = in_set(delim_set_r, char_in);
    hits.ctrl   = in_set(ctrl_set_r, char_in);
    hits.ignore = in_set(ignore_set_r, char_in);
  end

endmodule

// ===== rtl/core/clt_track.sv =====
// ----------------------------------------------------------------------------
// clt_track
// line position, argument count and after-control state; builds the result
// ----------------------------------------------------------------------------
module clt_track #(
  parameter int LINE_BYTES = clt_pkg::LINE_BYTES_DEF,
  parameter int MAX_ARGS   = clt_pkg::MAX_ARGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [clt_pkg::CHAR_W-1:0] char_in,
  input  clt_pkg::hit_t              hits,
  output logic                       res_vld,
  output clt_pkg::res_t              res
);

  localparam int WPW = $clog2(LINE_BYTES + 1);
  localparam int ACW = $clog2(MAX_ARGS + 1);

  logic [WPW-1:0] wpos_r, wpos_nxt, wpos_inc;
  logic [ACW-1:0] acnt_r, acnt_nxt, acnt_inc;
  logic           after_r, after_nxt;
  logic           line_full, args_full;

  assign wpos_inc  = wpos_r + WPW'(1);
  assign acnt_inc  = acnt_r + ACW'(1);
  assign line_full = (wpos_r >= WPW'(LINE_BYTES));
  assign args_full = (acnt_r >= ACW'(MAX_ARGS));

  always_comb begin
    wpos_nxt            = wpos_r;
    acnt_nxt            = acnt_r;
    after_nxt           = after_r;
    res_vld             = 1'b0;
    res.event_res       = clt_pkg::EV_STORE;
    res.position        = clt_pkg::POS_W'(wpos_r);
    res.value           = '0;
    res.arg_index       = '0;
    res.starts_argument = 1'b0;
    res.line_length     = '0;
    res.arg_count       = '0;
    if (line_full || args_full) begin
      res.position = '0;
      if (hits.commit) begin
        wpos_nxt      = '0;
        acnt_nxt      = '0;
        after_nxt     = 1'b0;
        res_vld       = 1'b1;
        res.event_res = line_full ? clt_pkg::EV_LINE_OVF : clt_pkg::EV_ARG_OVF;
      end
    end else if (acnt_r == '0 && hits.ignore) begin
      res_vld = 1'b0;
    end else if (hits.delim || hits.ctrl) begin
      if (wpos_r != '0) begin
        wpos_nxt      = wpos_inc;
        acnt_nxt      = acnt_inc;
        res_vld       = 1'b1;
        res.arg_index = clt_pkg::ARG_W'(acnt_inc);
        if (hits.delim) begin
          res.event_res = clt_pkg::EV_SEP;
        end else begin
          after_nxt     = 1'b1;
          res.event_res = clt_pkg::EV_CTRL;
          res.value     = char_in;
        end
      end
    end else if (hits.commit) begin
      wpos_nxt  = '0;
      acnt_nxt  = '0;
      after_nxt = 1'b0;
      if (wpos_r != '0) begin
        res_vld         = 1'b1;
        res.event_res   = clt_pkg::EV_COMMIT;
        res.arg_index   = clt_pkg::ARG_W'(acnt_r);
        res.line_length = clt_pkg::LEN_W'(wpos_inc);
        res.arg_count   = clt_pkg::ARG_W'(acnt_r);
      end
    end else begin
      wpos_nxt      = wpos_inc;
      res_vld       = 1'b1;
      res.value     = char_in;
      res.arg_index = clt_pkg::ARG_W'(acnt_r);
      if (after_r) begin
        after_nxt           = 1'b0;
        acnt_nxt            = acnt_inc;
        res.arg_index       = clt_pkg::ARG_W'(acnt_inc);
        res.starts_argument = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      acnt_r  <= '0;
      after_r <= 1'b0;
    end else if (step) begin
      wpos_r  <= wpos_nxt;
      acnt_r  <= acnt_nxt;
      after_r <= after_nxt;
    end
  end

`ifndef SYNTHESIS
  a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= WPW'(LINE_BYTES))
    else $error("write position beyond line size");
  a_acnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r <= ACW'(MAX_ARGS))
    else $error("argument count beyond limit");
  a_after_arg: assert property (@(posedge clk) disable iff (!rst_n)
    after_r |-> (acnt_r != '0 && wpos_r != '0))
    else $error("after-control flag set in command word");
  a_commit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_vld && res.event_res == clt_pkg::EV_COMMIT) |=>
      (wpos_r == '0 && acnt_r == '0 && !after_r))
    else $error("line state not cleared after commit");
`endif

endmodule

// ===== rtl/core/clt_out_reg.sv =====
// ----------------------------------------------------------------------------
// clt_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module clt_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  clt_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          free,
  output logic          out_vld,
  output clt_pkg::res_t res_out
);

  logic          vld_r;
  clt_pkg::res_t res_r;

  assign free    = !vld_r || !out_stall;
  assign out_vld = vld_r;
  assign res_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== rtl/core/command_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// sorts text bytes into stored bytes, separators, control arguments, commits
// and overflows against four configurable character sets
// ----------------------------------------------------------------------------
// input channel: one byte per beat on in_character with in_valid / in_stall
// output channel: at most one result beat per input byte with out_valid /
//   out_stall; dropped bytes (leading separators, ignored bytes, empty lines,
//   bytes discarded in overflow) give no beat
// config channel: cfg_valid / cfg_ready, cfg_ready is always high; index 0
//   commit set, 1 delimiter set, 2 control set, 3 ignore set, others ignored
// path: a byte taken lands in the input register, and its result is then
//   loaded into the output register, which drives out_valid
// throughput: one byte per cycle unless a result waits on a stalled output;
//   the line position and argument count are updated once per byte
// stall: while the output register holds an untaken beat, a byte that makes
//   a result waits in the input register and in_stall rises; bytes that give
//   no result still pass
// reset: sets cleared to zero, line state cleared, both registers empty
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit #(
  parameter int LINE_BYTES = clt_pkg::LINE_BYTES_DEF,
  parameter int MAX_ARGS   = clt_pkg::MAX_ARGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [clt_pkg::CHAR_W-1:0]    in_character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [clt_pkg::EV_W-1:0]      out_event_res,
  output logic [clt_pkg::POS_W-1:0]     out_position,
  output logic [clt_pkg::CHAR_W-1:0]    out_value,
  output logic [clt_pkg::ARG_W-1:0]     out_arg_index,
  output logic                          out_starts_argument,
  output logic [clt_pkg::LEN_W-1:0]     out_line_length,
  output logic [clt_pkg::ARG_W-1:0]     out_arg_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clt_pkg::SET_W-1:0]     cfg_data
);

  logic                       in_vld_r;
  logic [clt_pkg::CHAR_W-1:0] char_r;
  clt_pkg::hit_t              hits;
  logic                       res_vld;
  clt_pkg::res_t              res, res_q;
  logic                       out_free;
  logic                       step;
  logic                       in_take;

  assign cfg_ready = 1'b1;
  assign step      = in_vld_r && (out_free || !res_vld);
  assign in_stall  = in_vld_r && !step;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_character;
    end
  end

  clt_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_in   (char_r),
    .hits      (hits)
  );

  clt_track #(
    .LINE_BYTES (LINE_BYTES),
    .MAX_ARGS   (MAX_ARGS)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .char_in (char_r),
    .hits    (hits),
    .res_vld (res_vld),
    .res     (res)
  );

  clt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_vld),
    .res_in    (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_vld   (out_valid),
    .res_out   (res_q)
  );

  assign out_event_res       = res_q.event_res;
  assign out_position        = res_q.position;
  assign out_value           = res_q.value;
  assign out_arg_index       = res_q.arg_index;
  assign out_starts_argument = res_q.starts_argument;
  assign out_line_length     = res_q.line_length;
  assign out_arg_count       = res_q.arg_count;

`ifndef SYNTHESIS
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (in_vld_r && $stable(char_r)))
    else $error("held input byte lost or changed");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (res_vld && out_valid && out_stall))
    else $error("input stalled without a blocked result");
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_vld) |=> out_valid)
    else $error("result beat not registered");
`endif

endmodule
